>>> hdl/lbp_pkg.sv
// Package: shared types and constants for the pyramid LBP/LTP code generator.
`default_nettype none
package lbp_pkg;
    localparam int CNT_W     = 14;
    localparam int FIDX_W    = 22;
    localparam logic [CNT_W-1:0] COUNT_MAX = 14'd16383;

    localparam logic [2:0] REG_ROWS   = 3'd0;
    localparam logic [2:0] REG_COLS   = 3'd1;
    localparam logic [2:0] REG_TMODE  = 3'd2;
    localparam logic [2:0] REG_THRESH = 3'd3;
    localparam logic [2:0] REG_LIMIT  = 3'd4;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    typedef struct packed {
        logic [6:0]       rows;
        logic [6:0]       cols;
        logic             tmode;
        logic [7:0]       thresh;
        logic [CNT_W-1:0] limit;
    } t_cfg;

    // neighbor offsets, bit order up-left .. down-right
    function automatic logic signed [1:0] nb_dy(input logic [2:0] i);
        case (i)
            3'd0, 3'd1, 3'd2: nb_dy = -2'sd1;
            3'd3, 3'd4:       nb_dy = 2'sd0;
            default:          nb_dy = 2'sd1;
        endcase
    endfunction

    function automatic logic signed [1:0] nb_dx(input logic [2:0] i);
        case (i)
            3'd0, 3'd3, 3'd5: nb_dx = -2'sd1;
            3'd1, 3'd6:       nb_dx = 2'sd0;
            default:          nb_dx = 2'sd1;
        endcase
    endfunction
endpackage
`default_nettype wire

>>> hdl/lbp_ltp_pyramid_sparse_codes.sv
// Top level: pyramid local binary / ternary pattern code generator.
`default_nettype none
// Usage:
//   Commands transfer on i_start while o_busy is low. A load command
//   (i_req_type 0) writes i_pixel at the next column-major address, then
//   waits in S_WAIT before the next command can transfer. An advance
//   command (i_req_type 1) reads the center and the eight neighbors of
//   the next interior 3x3 window through the single store read port,
//   one per cycle in binary mode, and compares each against the center in
//   one shared comparator. Binary mode: the code is strobed on o_valid in
//   the cycle in which the next command can transfer, unless the level
//   ends. Ternary mode: each neighbor takes two compares; the two codes
//   are strobed one after the other, low code first. An advance after the
//   end gives one result with index 0.
//   When a level ends, the 2x2 halving walks the store: each output pixel
//   of each pass takes two reads, one write and one step; the column pass
//   covers w/2*h_even pixels, the row pass w/2*h/2. Reads share one port.
//   Results carry o_last_of_run on the final result of the command and
//   o_done_res once the sequence has ended. The receiver cannot stall:
//   each result is on the ports for exactly one cycle.
//   Reset (synchronous, active low) restores register defaults and the
//   scan state; store contents stay undefined until loaded. Writing
//   image_rows or image_cols restarts the scan for a new image.
//   The user makes config writes on i_cfg_we with the block idle; unenforced.
module lbp_ltp_pyramid_sparse_codes #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLS    = 64,
    parameter int STORE_WIDTH = 16
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_start,
    output logic                   o_busy,
    input  wire                    i_req_type,
    input  wire [7:0]              i_pixel,
    input  wire                    i_cfg_we,
    input  wire [2:0]              i_cfg_index,
    input  wire [13:0]             i_cfg_data,
    output logic                   o_valid,
    output logic [21:0]            o_feature_index,
    output logic                   o_last_of_run,
    output logic                   o_done_res
);
    import lbp_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int SW    = STORE_WIDTH;
    localparam logic [SW:0] SMAX = {1'b0, {SW{1'b1}}};

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CRD   = 10'b0000000010,
        S_NRD   = 10'b0000000100,
        S_EMIT1 = 10'b0000001000,
        S_EMIT2 = 10'b0000010000,
        S_DRDA  = 10'b0000100000,
        S_DRDB  = 10'b0001000000,
        S_DWR   = 10'b0010000000,
        S_DNEXT = 10'b0100000000,
        S_WAIT  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    t_cfg   r_cfg;

    logic [AW-1:0]   r_lptr;
    logic [CW-1:0]   r_lw;
    logic [RW-1:0]   r_lh;
    logic [CW-1:0]   r_sc;
    logic [RW-1:0]   r_sr;
    logic [CNT_W-1:0] r_cnt;
    logic            r_fin;

    logic [SW-1:0]   r_c;      // center value
    logic [3:0]      r_ni;     // neighbor step, 8 = all neighbors compared
    logic [7:0]      r_lo, r_hi;
    logic            r_pass;   // 0 column pass, 1 row pass
    logic [CW-1:0]   r_dx;
    logic [RW-1:0]   r_dy;
    logic [SW-1:0]   r_a;
    logic            r_ph;     // ternary compare phase, 1 = second compare

    // effective geometry
    logic [RW-1:0] eff_rows;
    logic [CW-1:0] eff_cols;
    always_comb begin
        eff_rows = (int'(r_cfg.rows) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(r_cfg.rows);
        eff_cols = (int'(r_cfg.cols) > MAX_COLS) ? CW'(MAX_COLS) : CW'(r_cfg.cols);
    end

    // store
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [SW-1:0] wdata, rdata;
    lbp_store #(.DEPTH(DEPTH), .DW(SW), .AW(AW)) u_store (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    function automatic logic [AW-1:0] addr_of(input logic [RW:0] y, input logic [CW:0] x,
                                              input logic [RW-1:0] rows);
        logic [AW+RW+CW:0] a;
        a = (AW+RW+CW+1)'(y) + (AW+RW+CW+1)'(x) * (AW+RW+CW+1)'(rows);
        return AW'(a);
    endfunction

    // neighbor coordinates: read one step ahead so data lines up with r_ni
    logic [2:0]  ni3;
    logic [2:0]  rd_ni;
    logic [RW:0] ny;
    logic [CW:0] nx;
    always_comb begin
        ni3   = r_ni[2:0];
        rd_ni = (r_state == S_NRD && (!r_cfg.tmode || r_ph)) ? ni3 + 3'd1 : ni3;
        ny    = (RW+1)'(r_sr) + (RW+1)'($signed(nb_dy(rd_ni)));
        nx    = (CW+1)'(r_sc) + (CW+1)'($signed(nb_dx(rd_ni)));
    end

    // shared comparator unit
    logic [SW+1:0] cmp_l, cmp_r;
    logic          cmp_lt;
    logic          hi_side;   // second compare of a ternary step
    logic [SW+1:0] thr_ext;
    assign thr_ext = (SW+2)'(r_cfg.thresh);
    always_comb begin
        if (!r_cfg.tmode) begin
            cmp_l = (SW+2)'(rdata);
            cmp_r = (SW+2)'(r_c);
        end else if (!hi_side) begin
            cmp_l = (SW+2)'(rdata) + thr_ext;
            cmp_r = (SW+2)'(r_c);
        end else begin
            cmp_l = (SW+2)'(r_c) + thr_ext;
            cmp_r = (SW+2)'(rdata);
        end
        cmp_lt = cmp_l < cmp_r;
    end
    assign hi_side = r_ph;

    // pairwise sum with saturation
    logic [SW:0]   sum;
    logic [SW-1:0] sum_sat;
    always_comb begin
        sum     = (SW+1)'(r_a) + (SW+1)'(rdata);
        sum_sat = (sum > SMAX) ? {SW{1'b1}} : sum[SW-1:0];
    end

    // halved sizes
    logic [CW-1:0] hw;
    logic [RW-1:0] hh, eh;
    assign hw = r_lw >> 1;
    assign hh = r_lh >> 1;
    assign eh = {r_lh[RW-1:1], 1'b0};

    // downsample addresses
    logic [RW:0] da_y, db_y;
    logic [CW:0] da_x, db_x;
    always_comb begin
        if (!r_pass) begin
            da_y = (RW+1)'(r_dy);              da_x = (CW+1)'({r_dx, 1'b0});
            db_y = (RW+1)'(r_dy);              db_x = (CW+1)'({r_dx, 1'b0}) + 1'b1;
        end else begin
            da_y = (RW+1)'({r_dy, 1'b0});      da_x = (CW+1)'(r_dx);
            db_y = (RW+1)'({r_dy, 1'b0}) + 1'b1; db_x = (CW+1)'(r_dx);
        end
    end

    // scan advance
    logic [RW-1:0] nsr;
    logic [CW-1:0] nsc;
    logic          col_wrap, lvl_end;
    always_comb begin
        nsr      = r_sr + 1'b1;
        nsc      = r_sc + 1'b1;
        col_wrap = ((RW+1)'(nsr) + 1'b1) >= (RW+1)'(r_lh);
        lvl_end  = col_wrap && (((CW+1)'(nsc) + 1'b1) >= (CW+1)'(r_lw));
    end

    logic [CNT_W-1:0] cnt_inc;
    assign cnt_inc = (r_cnt < COUNT_MAX) ? r_cnt + 1'b1 : r_cnt;

    logic small_lvl;
    assign small_lvl = (r_lw < CW'(3)) || (r_lh < RW'(3));

    // next level too small to scan once this one is halved
    logic small_next;
    assign small_next = (hw < CW'(3)) || (hh < RW'(3));

    logic cmd;
    assign cmd = i_start && !o_busy;
    assign o_busy = (r_state != S_IDLE);

    // store port steering
    always_comb begin
        we    = 1'b0;
        waddr = r_lptr;
        wdata = SW'(i_pixel);
        raddr = addr_of(ny, nx, eff_rows);
        if (cmd && i_req_type == REQ_LOAD) begin
            we = 1'b1;
        end else if (r_state == S_IDLE) begin
            raddr = addr_of((RW+1)'(r_sr), (CW+1)'(r_sc), eff_rows);
        end else if (r_state == S_DRDA) begin
            raddr = addr_of(da_y, da_x, eff_rows);
        end else if (r_state == S_DRDB) begin
            raddr = addr_of(db_y, db_x, eff_rows);
        end else if (r_state == S_DWR) begin
            we    = 1'b1;
            waddr = addr_of((RW+1)'(r_dy), (CW+1)'(r_dx), eff_rows);
            wdata = sum_sat;
        end
    end

    logic end_after;   // code count reaches the limit once this window is out
    logic fin_after;   // sequence ends with this window

    logic dn_last_x, dn_last_y;
    assign dn_last_y = r_pass ? ((r_dy + 1'b1) >= hh) : ((r_dy + 1'b1) >= eh);
    assign dn_last_x = (CW'(r_dx + 1'b1) >= hw);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (cmd) n_state = (i_req_type == REQ_LOAD) ? S_WAIT :
                                         ((r_fin || small_lvl) ? S_EMIT2 : S_CRD);
            S_CRD:   n_state = S_NRD;
            S_NRD:   if (r_ni == 4'd7 && (!r_cfg.tmode || r_ph)) n_state = S_EMIT1;
            S_EMIT1: n_state = r_cfg.tmode ? S_EMIT2 :
                               ((lvl_end && !end_after) ? S_DRDA : S_IDLE);
            S_EMIT2: n_state = (!r_fin && lvl_end && !end_after && !small_lvl)
                               ? S_DRDA : S_IDLE;
            S_DRDA:  n_state = S_DRDB;
            S_DRDB:  n_state = S_DWR;
            S_DWR:   n_state = S_DNEXT;
            S_DNEXT: n_state = (r_pass && dn_last_x && dn_last_y) ? S_IDLE : S_DRDA;
            S_WAIT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // in ternary mode the first code still has the second one to count
    logic [CNT_W-1:0] cnt_after;
    assign cnt_after = (r_cfg.tmode && r_state == S_EMIT1)
                       ? ((cnt_inc < COUNT_MAX) ? cnt_inc + 1'b1 : cnt_inc)
                       : cnt_inc;
    assign end_after = (cnt_after >= r_cfg.limit);
    assign fin_after = lvl_end && (end_after || small_next);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg   <= '{rows: 7'd64, cols: 7'd64, tmode: 1'b0, thresh: 8'd0,
                         limit: 14'd16383};
            r_lptr  <= '0;
            r_lw    <= CW'(MAX_COLS < 64 ? MAX_COLS : 64);
            r_lh    <= RW'(MAX_ROWS < 64 ? MAX_ROWS : 64);
            r_sc    <= CW'(1);
            r_sr    <= RW'(1);
            r_cnt   <= '0;
            r_fin   <= 1'b0;
            o_valid <= 1'b0;
            r_ph    <= 1'b0;
            r_ni    <= '0;
            r_pass  <= 1'b0;
            r_dx    <= '0;
            r_dy    <= '0;
        end else begin
            r_state <= n_state;
            o_valid <= (r_state == S_EMIT1) || (r_state == S_EMIT2);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ROWS:   r_cfg.rows   <= i_cfg_data[6:0];
                    REG_COLS:   r_cfg.cols   <= i_cfg_data[6:0];
                    REG_TMODE:  r_cfg.tmode  <= i_cfg_data[0];
                    REG_THRESH: r_cfg.thresh <= i_cfg_data[7:0];
                    REG_LIMIT:  r_cfg.limit  <= i_cfg_data[13:0];
                    default: ;
                endcase
                if (i_cfg_index == REG_ROWS || i_cfg_index == REG_COLS) begin
                    // restart on new geometry; sizes resolved from the new value
                    r_lptr <= '0;
                    r_sc   <= CW'(1);
                    r_sr   <= RW'(1);
                    r_cnt  <= '0;
                    r_fin  <= 1'b0;
                    if (i_cfg_index == REG_ROWS) begin
                        r_lh <= (int'(i_cfg_data[6:0]) > MAX_ROWS) ? RW'(MAX_ROWS)
                                                                   : RW'(i_cfg_data[6:0]);
                        r_lw <= eff_cols;
                    end else begin
                        r_lw <= (int'(i_cfg_data[6:0]) > MAX_COLS) ? CW'(MAX_COLS)
                                                                   : CW'(i_cfg_data[6:0]);
                        r_lh <= eff_rows;
                    end
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (cmd && i_req_type == REQ_LOAD) begin
                        r_lptr <= (32'(r_lptr) + 1 >= DEPTH) ? '0 : r_lptr + 1'b1;
                    end
                    r_ni <= '0;
                    r_ph <= 1'b0;
                    r_lo <= '0;
                    r_hi <= '0;
                end
                S_CRD: begin
                    r_c <= rdata;  // center arrives; first neighbor read issued now
                end
                S_NRD: begin
                    // rdata is the neighbor at r_ni
                    if (!r_cfg.tmode) begin
                        r_lo[ni3] <= cmp_lt;
                        r_ni <= r_ni + 1'b1;
                    end else if (!r_ph) begin
                        r_lo[ni3] <= cmp_lt;
                        r_ph <= 1'b1;
                    end else begin
                        r_hi[ni3] <= cmp_lt;
                        r_ph <= 1'b0;
                        r_ni <= r_ni + 1'b1;
                    end
                end
                S_EMIT1: begin
                    o_feature_index <= {r_cnt, r_lo};
                    o_last_of_run   <= !r_cfg.tmode;
                    o_done_res      <= fin_after;
                    r_cnt           <= cnt_inc;
                    if (!r_cfg.tmode) begin
                        r_sr <= col_wrap ? RW'(1) : nsr;
                        if (col_wrap) r_sc <= lvl_end ? CW'(1) : nsc;
                        if (fin_after) r_fin <= 1'b1;
                        r_pass <= 1'b0; r_dx <= '0; r_dy <= '0;
                    end
                end
                S_EMIT2: begin
                    o_last_of_run <= 1'b1;
                    if (r_fin || small_lvl) begin
                        o_feature_index <= '0;
                        o_done_res      <= 1'b1;
                        r_fin           <= 1'b1;
                    end else begin
                        o_feature_index <= {r_cnt, r_hi};
                        o_done_res      <= fin_after;
                        r_cnt <= cnt_inc;
                        r_sr <= col_wrap ? RW'(1) : nsr;
                        if (col_wrap) r_sc <= lvl_end ? CW'(1) : nsc;
                        if (fin_after) r_fin <= 1'b1;
                        r_pass <= 1'b0; r_dx <= '0; r_dy <= '0;
                    end
                end
                S_DRDA: ;
                S_DRDB: r_a <= rdata;
                S_DWR: ;
                S_DNEXT: begin
                    // advance y inner, x outer
                    if (!dn_last_y) begin
                        r_dy <= r_dy + 1'b1;
                    end else begin
                        r_dy <= '0;
                        if (!dn_last_x) begin
                            r_dx <= r_dx + 1'b1;
                        end else begin
                            r_dx <= '0;
                            if (!r_pass) begin
                                r_pass <= 1'b1;
                            end else begin
                                r_lw <= hw;
                                r_lh <= hh;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    a_idle_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |=> !o_valid) else $error("strobe after load");
    a_pair_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_of_run) |=> o_valid)
        else $error("first code of a pair not followed by the second");
    a_busy_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT1 || r_state == S_EMIT2) |=> o_valid)
        else $error("emit without strobe");
endmodule
`default_nettype wire

>>> hdl/lbp_store.sv
// Image store: single-port-write, registered-read memory.
`default_nettype none
module lbp_store #(
    parameter int DEPTH = 4096,
    parameter int DW    = 16,
    parameter int AW    = 12
) (
    input  wire          i_clk,
    input  wire          i_we,
    input  wire [AW-1:0] i_waddr,
    input  wire [DW-1:0] i_wdata,
    input  wire [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> tb/lbp_ltp_pyramid_sparse_codes_tb.sv
// Testbench for the pyramid binary / ternary pattern code generator.
`timescale 1ns / 1ps
module lbp_ltp_pyramid_sparse_codes_tb;
    import lbp_pkg::*;

    localparam int STORE_DEPTH = 64 * 64;
    localparam int SUM_MAX     = 65535;
    localparam int WATCHDOG    = 200000;

    typedef struct packed {
        logic [21:0] fidx;
        logic        last;
        logic        done;
    } t_code;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        i_req_type = REQ_LOAD;
    logic [7:0]  i_pixel = 8'd0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = REG_ROWS;
    logic [13:0] i_cfg_data = 14'd0;
    logic        o_busy;
    logic        o_valid;
    logic [21:0] o_feature_index;
    logic        o_last_of_run;
    logic        o_done_res;

    lbp_ltp_pyramid_sparse_codes dut (
        .i_clk, .i_rst_n, .i_start, .o_busy, .i_req_type, .i_pixel,
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_valid, .o_feature_index, .o_last_of_run, .o_done_res
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the block: registers, store and scan state.
    int unsigned img_mem [STORE_DEPTH];
    int unsigned cfg_rows, cfg_cols, cfg_tmode, cfg_thresh, cfg_limit;
    int unsigned ld_ptr, lvl_w, lvl_h, col_pos, row_pos, n_codes;
    bit          seq_done;

    t_code       pending_codes[$];
    int          n_errors = 0;
    int          n_items = 0;
    int          n_codes_seen = 0;
    int          n_images = 0;
    int          quiet_cycles = 0;
    bit          no_gaps = 1'b0;

    function automatic int unsigned rows_eff();
        return cfg_rows > 64 ? 64 : cfg_rows;
    endfunction

    function automatic int unsigned cols_eff();
        return cfg_cols > 64 ? 64 : cfg_cols;
    endfunction

    function automatic int unsigned rd_px(int unsigned y, int unsigned x);
        int unsigned a;
        a = y + x * rows_eff();
        return a < STORE_DEPTH ? img_mem[a] : 0;
    endfunction

    function automatic void wr_px(int unsigned y, int unsigned x, int unsigned v);
        int unsigned a;
        a = y + x * rows_eff();
        if (v > SUM_MAX) v = SUM_MAX;
        if (a < STORE_DEPTH) img_mem[a] = v;
    endfunction

    function automatic void restart_scan();
        ld_ptr = 0;
        lvl_w = cols_eff();
        lvl_h = rows_eff();
        col_pos = 1;
        row_pos = 1;
        n_codes = 0;
        seq_done = 1'b0;
    endfunction

    // Crop to even size, then halve columns and rows by pairwise sums.
    function automatic void halve_level();
        int unsigned w, h;
        w = (lvl_w & ~1) / 2;
        h = lvl_h & ~1;
        for (int unsigned x = 0; x < w; x++)
            for (int unsigned y = 0; y < h; y++)
                wr_px(y, x, rd_px(y, 2 * x) + rd_px(y, 2 * x + 1));
        h = h / 2;
        for (int unsigned y = 0; y < h; y++)
            for (int unsigned x = 0; x < w; x++)
                wr_px(y, x, rd_px(2 * y, x) + rd_px(2 * y + 1, x));
        lvl_w = w;
        lvl_h = h;
    endfunction

    function automatic logic [21:0] next_index(logic [7:0] pat);
        logic [21:0] v;
        v = {n_codes[13:0], pat};
        if (n_codes < COUNT_MAX) n_codes++;
        return v;
    endfunction

    function automatic void apply_cfg(logic [2:0] idx, logic [13:0] val);
        case (idx)
            REG_ROWS: begin
                cfg_rows = val[6:0];
                restart_scan();
            end
            REG_COLS: begin
                cfg_cols = val[6:0];
                restart_scan();
            end
            REG_TMODE:  cfg_tmode = val[0];
            REG_THRESH: cfg_thresh = val[7:0];
            REG_LIMIT:  cfg_limit = val;
            default: ;
        endcase
    endfunction

    // Predict the codes caused by one command and queue them.
    function automatic void predict_codes(logic rt, logic [7:0] px);
        int unsigned c, v, y, x, k;
        logic [7:0]  lo, hi;
        logic [21:0] idx[2];
        int          dy[8] = '{-1, -1, -1, 0, 0, 1, 1, 1};
        int          dx[8] = '{-1, 0, 1, -1, 1, -1, 0, 1};
        t_code       r;
        if (rt == REQ_LOAD) begin
            img_mem[ld_ptr] = px;
            ld_ptr = (ld_ptr + 1 >= STORE_DEPTH) ? 0 : ld_ptr + 1;
            return;
        end
        if (seq_done || lvl_w < 3 || lvl_h < 3) begin
            seq_done = 1'b1;
            r = '{fidx: 22'd0, last: 1'b1, done: 1'b1};
            pending_codes.push_back(r);
            return;
        end
        y = row_pos;
        x = col_pos;
        lo = 8'd0;
        hi = 8'd0;
        c = rd_px(y, x);
        for (int i = 0; i < 8; i++) begin
            v = rd_px(y + dy[i], x + dx[i]);
            if (cfg_tmode != 0) begin
                if (v + cfg_thresh < c) lo[i] = 1'b1;
                if (v > c + cfg_thresh) hi[i] = 1'b1;
            end else if (v < c) begin
                lo[i] = 1'b1;
            end
        end
        idx[0] = next_index(lo);
        k = 1;
        if (cfg_tmode != 0) begin
            idx[1] = next_index(hi);
            k = 2;
        end
        row_pos++;
        if (row_pos + 1 >= lvl_h) begin
            row_pos = 1;
            col_pos++;
            if (col_pos + 1 >= lvl_w) begin
                col_pos = 1;
                if (n_codes >= cfg_limit) begin
                    seq_done = 1'b1;
                end else begin
                    halve_level();
                    if (lvl_w < 3 || lvl_h < 3) seq_done = 1'b1;
                end
            end
        end
        for (int unsigned j = 0; j < k; j++) begin
            r = '{fidx: idx[j], last: (j + 1 == k), done: seq_done};
            pending_codes.push_back(r);
        end
    endfunction

    // Compare each strobed code with the oldest prediction.
    always @(posedge i_clk) begin
        t_code want;
        if (i_rst_n && o_valid) begin
            n_codes_seen++;
            if (pending_codes.size() == 0) begin
                $display("%0t: unexpected code idx=%0d last=%0b done=%0b", $time,
                         o_feature_index, o_last_of_run, o_done_res);
                n_errors++;
            end else begin
                want = pending_codes.pop_front();
                if (o_feature_index !== want.fidx) begin
                    $display("%0t: feature_index expected %0d got %0d", $time,
                             want.fidx, o_feature_index);
                    n_errors++;
                end
                if (o_last_of_run !== want.last) begin
                    $display("%0t: last_of_run expected %0b got %0b", $time,
                             want.last, o_last_of_run);
                    n_errors++;
                end
                if (o_done_res !== want.done) begin
                    $display("%0t: done_res expected %0b got %0b", $time,
                             want.done, o_done_res);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: count cycles in which nothing transfers.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || i_cfg_we) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("%0t: watchdog expired, %0d codes outstanding", $time,
                     pending_codes.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Send one command; return at a falling edge with start still high.
    task automatic send_cmd(logic rt, logic [7:0] px);
        if (!no_gaps && $urandom_range(99) < 11) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_req_type <= rt;
        i_pixel <= px;
        do @(posedge i_clk); while (o_busy);
        predict_codes(rt, px);
        n_items++;
        @(negedge i_clk);
    endtask

    // Drop start and hold until all codes are in and the block is quiet.
    task automatic drain();
        i_start <= 1'b0;
        @(negedge i_clk);
        while (pending_codes.size() != 0 || o_busy) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [13:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        apply_cfg(idx, val);
        @(negedge i_clk);
    endtask

    // Set up a new image; mode 0 random, 1 all zero, 2 all max, 3 ramp.
    task automatic load_image(int unsigned r, int unsigned c, int mode);
        int unsigned n;
        drain();
        write_reg(REG_ROWS, 14'(r));
        write_reg(REG_COLS, 14'(c));
        n = (r > 64 ? 64 : r) * (c > 64 ? 64 : c);
        n_images++;
        for (int unsigned i = 0; i < n; i++) begin
            case (mode)
                1:       send_cmd(REQ_LOAD, 8'd0);
                2:       send_cmd(REQ_LOAD, 8'hFF);
                3:       send_cmd(REQ_LOAD, i[7:0] * 8'd37);
                default: send_cmd(REQ_LOAD, 8'($urandom_range(255)));
            endcase
        end
    endtask

    // Advance until the sequence ends, then poke it a few more times.
    task automatic run_to_end(int extra);
        while (!seq_done) send_cmd(REQ_ADVANCE, 8'($urandom_range(255)));
        repeat (extra) send_cmd(REQ_ADVANCE, 8'($urandom_range(255)));
    endtask

    task automatic set_mode(int unsigned tm, int unsigned th, int unsigned lim);
        drain();
        write_reg(REG_TMODE, 14'(tm));
        write_reg(REG_THRESH, 14'(th));
        write_reg(REG_LIMIT, 14'(lim));
    endtask

    // Flat images: nothing below; then a ternary ramp with threshold 255 sets no bits.
    task automatic test_flat_images();
        set_mode(0, 0, 16383);
        load_image(3, 3, 1);
        run_to_end(1);
        load_image(3, 3, 2);
        run_to_end(0);
        set_mode(1, 255, 16383);
        load_image(3, 4, 3);
        run_to_end(1);
    endtask

    // Ternary with a mid threshold on a ramp that spans both sides, then zero threshold.
    task automatic test_ternary_band();
        set_mode(1, 20, 16383);
        load_image(6, 6, 3);
        run_to_end(1);
        set_mode(1, 0, 16383);
        load_image(4, 3, 0);
        run_to_end(0);
    endtask

    // Images under 3x3 end at once; a geometry write restarts a finished run.
    task automatic test_tiny_image();
        set_mode(0, 0, 16383);
        load_image(2, 5, 0);
        run_to_end(2);
        load_image(0, 0, 0);
        run_to_end(1);
    endtask

    // Oversized rows, then oversized columns, clamp to 64; sums on bright input.
    task automatic test_oversize();
        set_mode(0, 0, 16383);
        load_image(100, 3, 2);
        run_to_end(1);
        load_image(3, 127, 0);
        run_to_end(0);
    endtask

    // Stop at the first level end once the limit is hit; then a full pyramid.
    task automatic test_limit();
        set_mode(1, 5, 1);
        load_image(8, 8, 0);
        run_to_end(1);
        set_mode(0, 0, 16383);
        load_image(16, 16, 2);
        run_to_end(1);
    endtask

    task automatic test_random(int target);
        int unsigned r, c;
        while (n_items < target) begin
            no_gaps = (n_items >= target - 450) && (n_items < target - 200);
            set_mode($urandom_range(1), $urandom_range(99) < 20 ? $urandom_range(255)
                     : $urandom_range(30), $urandom_range(99) < 20 ? $urandom_range(1, 60)
                     : 16383);
            r = $urandom_range(99) < 8 ? $urandom_range(2) : $urandom_range(3, 12);
            c = $urandom_range(99) < 8 ? $urandom_range(2) : $urandom_range(3, 12);
            load_image(r, c, $urandom_range(99) < 10 ? $urandom_range(1, 3) : 0);
            run_to_end($urandom_range(2));
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        cfg_rows = 64;
        cfg_cols = 64;
        cfg_tmode = 0;
        cfg_thresh = 0;
        cfg_limit = 16383;
        restart_scan();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_flat_images();
        test_ternary_band();
        test_tiny_image();
        test_oversize();
        test_limit();
        test_random(1700);
        drain();
        repeat (50) @(negedge i_clk);
        $display("Ran %0d commands over %0d images, checked %0d codes.",
                 n_items, n_images, n_codes_seen);
        $display("Covered binary and ternary modes, tiny and oversized images, limits.");
        if (n_errors == 0 && pending_codes.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
